// ===== rtl/acrc_pkg.sv =====
// shared types, constants and helpers of the arc centre and radius pipeline
`timescale 1ns / 1ps
package acrc_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int HALF_SHIFT = 29 - FRAC_BITS;
   localparam int RW = 34;   // rotation datapath width
   localparam int VW = 36;   // vectoring datapath width
   localparam int NW = 64;   // dividend width
   localparam int DW = 32;   // divisor width
   localparam int QW = 33;   // quotient width

   localparam logic signed [RW-1:0] K_Q30       = 34'sd652032874;
   localparam logic [32:0]          PI_Q30      = 33'd3373259426;
   localparam logic [32:0]          HALF_PI_Q30 = 33'd1686629713;
   localparam logic signed [31:0]   I32_MAX     = 32'sh7FFFFFFF;
   localparam logic signed [31:0]   I32_MIN     = 32'sh80000000;
   localparam logic [30:0]          RAD_MAX     = 31'h7FFFFFFF;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ZERO_CHORD = 2'd1,
      ST_ZERO_ANGLE = 2'd2,
      ST_OVERFLOW   = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] mx;
      logic [31:0] my;
      logic [31:0] adx;
      logic [31:0] ady;
      logic        dx_neg;
      logic        dx_zero;
      logic        dy_neg;
      logic        dy_zero;
      logic        zchord;
      logic        zangle;
      logic [4:0]  sh;
      logic        szero;
      logic        cs_neg;
      logic [31:0] mag_s;
      logic        ovf_x;
      logic        ovf_y;
      logic        ovf_r;
   } side_type;

   typedef struct packed {
      logic [RW-1:0] rx;
      logic [RW-1:0] ry;
      logic [RW-1:0] rz;
      logic [VW-1:0] vx;
      logic [VW-1:0] vy;
   } cordic_type;

   typedef struct packed {
      logic [NW-1:0] rem_x;
      logic [NW-1:0] rem_y;
      logic [NW-1:0] rem_r;
      logic [DW-1:0] den_o;
      logic [DW-1:0] den_r;
      logic [QW-1:0] q_x;
      logic [QW-1:0] q_y;
      logic [QW-1:0] q_r;
   } div_type;

   function automatic logic signed [RW-1:0] atan_q30(input int idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'h3243F6A8;
         1:  v = 32'h1DAC6705;
         2:  v = 32'h0FADBAFC;
         3:  v = 32'h07F56EA6;
         4:  v = 32'h03FEAB76;
         5:  v = 32'h01FFD55B;
         6:  v = 32'h00FFFAAA;
         7:  v = 32'h007FFF55;
         8:  v = 32'h003FFFEA;
         9:  v = 32'h001FFFFD;
         10: v = 32'h000FFFFF;
         11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF;
         13: v = 32'h0001FFFF;
         14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF;
         16: v = 32'h00003FFF;
         17: v = 32'h00001FFF;
         18: v = 32'h00000FFF;
         19: v = 32'h000007FF;
         20: v = 32'h000003FF;
         21: v = 32'h000001FF;
         22: v = 32'h000000FF;
         23: v = 32'h0000007F;
         24: v = 32'h0000003F;
         25: v = 32'h0000001F;
         26: v = 32'h0000000F;
         27: v = 32'h00000008;
         28: v = 32'h00000004;
         29: v = 32'h00000002;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return $signed({{(RW-32){1'b0}}, v});
   endfunction

   // index of the highest set bit
   function automatic logic [4:0] msb_index(input logic [31:0] m);
      logic [4:0] idx;
      idx = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (m[i]) idx = 5'(i);
      end
      return idx;
   endfunction

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [NW:0] div_step(input logic [NW-1:0] rem,
                                            input logic [DW-1:0] den,
                                            input int sb);
      logic [NW-1:0] den_ext;
      logic          take;
      den_ext = NW'(den);
      take    = (rem >> sb) >= den_ext;
      return take ? {1'b1, rem - (den_ext << sb)} : {1'b0, rem};
   endfunction

endpackage

// ===== rtl/arc_center_radius_from_chord.sv =====
// top level: arc centre and radius from two endpoints and an included angle
`timescale 1ns / 1ps
// usage
//  req channel: one beat per arc, tdata holds start_x, start_y, end_x, end_y (q15.16)
//   and included_angle (q3.16, positive counterclockwise)
//  rsp channel: one beat per arc, tdata holds center_x, center_y and radius_out,
//   tuser holds the status code (ok, zero chord, zero angle, overflow)
//  throughput: one arc per cycle while the output is not stalled; every stage is a
//   fully unrolled cell: one input stage, one cordic cell per step plus a closing
//   register, multiply, scale and divider set-up stages, 33 divider cells and one
//   output register
//  the whole chain advances together; when the receiver stalls a full output
//   register, every stage holds and req_tready drops in the same cycle
//  reset clears the valid bit of every stage, payload registers are not reset
//  results leave in the order that arcs arrive
module arc_center_radius_from_chord #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x [31:0], start_y [63:32], end_x [95:64], end_y [127:96],
   // included_angle [147:128], zero pad [151:148]
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // center_x [31:0], center_y [63:32], radius_out [94:64], zero pad [95]
   output logic [95:0]  rsp_tdata,
   // status [1:0]
   output logic [1:0]   rsp_tuser
);
   import acrc_pkg::*;

   logic adv;

   // input stage: chord, midpoint and angle
   logic               a_valid_ff;
   logic signed [32:0] a_dx_ff, a_dy_ff, a_dx_in, a_dy_in;
   logic signed [31:0] a_mx_ff, a_my_ff, a_mx_in, a_my_in;
   logic signed [19:0] a_ia_ff;
   logic signed [32:0] sum_x, sum_y;

   // cordic chain
   logic       cv [0:CORDIC_STEPS];
   cordic_type cd [0:CORDIC_STEPS];
   side_type   cs [0:CORDIC_STEPS];

   // angle reduction and chord normalisation
   logic [19:0]          ia_mag;
   logic [32:0]          hm0, hm;
   logic signed [RW-1:0] z_pos, z_sel;
   logic [32:0]          adx_w, ady_w;
   logic [31:0]          m_big;
   logic [4:0]           top, sh;
   cordic_type           b_in;
   side_type             b_side;

   // multiply stage
   logic                 m_valid_ff;
   logic [63:0]          m_px_ff, m_py_ff, m_lf_ff, m_px_in, m_py_in, m_lf_in;
   side_type             m_side_ff, m_side_in;
   logic signed [RW-1:0] c_v, s_v, c_abs, s_abs;
   logic signed [VW-1:0] l_v;

   // scale stage
   logic        n_valid_ff;
   logic [63:0] n_px_ff, n_py_ff, n_nr_ff;
   logic [64:0] numr_w;
   side_type    n_side_ff;

   // divider chain
   logic     dv [0:QW];
   div_type  dd [0:QW];
   side_type ds [0:QW];
   div_type  p_in;
   side_type p_side;

   // output stage
   logic               o_valid_ff;
   logic [31:0]        o_cx_ff, o_cy_ff, o_cx_in, o_cy_in;
   logic [30:0]        o_r_ff, o_r_in;
   status_type         o_st_ff, o_st_in;
   side_type           fs;
   div_type            fd;
   logic signed [34:0] ox_sum, oy_sum;
   logic               neg_x, neg_y, sat_x, sat_y, sat_r;
   logic signed [31:0] res_x, res_y, inf_x, inf_y;

   // the chain moves whenever the output register can take a new beat
   assign adv        = !o_valid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- input stage ----------------
   always_comb begin
      a_dx_in = $signed({req_tdata[95], req_tdata[95:64]})
              - $signed({req_tdata[31], req_tdata[31:0]});
      a_dy_in = $signed({req_tdata[127], req_tdata[127:96]})
              - $signed({req_tdata[63], req_tdata[63:32]});
      sum_x   = $signed({req_tdata[95], req_tdata[95:64]})
              + $signed({req_tdata[31], req_tdata[31:0]});
      sum_y   = $signed({req_tdata[127], req_tdata[127:96]})
              + $signed({req_tdata[63], req_tdata[63:32]});
      // floor of half the sum
      a_mx_in = sum_x[32:1];
      a_my_in = sum_y[32:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_dx_ff <= a_dx_in;
         a_dy_ff <= a_dy_in;
         a_mx_ff <= a_mx_in;
         a_my_ff <= a_my_in;
         a_ia_ff <= $signed(req_tdata[147:128]);
      end
   end

   // ---------------- half angle reduction and chord normalisation ----------------
   always_comb begin
      ia_mag = a_ia_ff[19] ? (~a_ia_ff + 20'd1) : a_ia_ff;
      hm0    = 33'(ia_mag) << HALF_SHIFT;
      // the scaled angle stays below twice pi, one subtraction reduces it
      hm     = (hm0 >= PI_Q30) ? hm0 - PI_Q30 : hm0;
      z_pos  = $signed(RW'(hm));
      z_sel  = (hm > HALF_PI_Q30) ? z_pos - $signed(RW'(PI_Q30)) : z_pos;

      adx_w  = a_dx_ff[32] ? -a_dx_ff : a_dx_ff;
      ady_w  = a_dy_ff[32] ? -a_dy_ff : a_dy_ff;
      m_big  = (adx_w[31:0] > ady_w[31:0]) ? adx_w[31:0] : ady_w[31:0];
      top    = msb_index(m_big);
      sh     = (top < 5'd29) ? 5'd29 - top : 5'd0;

      b_in.rx = K_Q30;
      b_in.ry = '0;
      b_in.rz = a_ia_ff[19] ? -z_sel : z_sel;
      b_in.vx = VW'(adx_w[31:0]) << sh;
      b_in.vy = VW'(a_dy_ff) << sh;
      if (a_dy_ff[32]) b_in.vy = $signed(VW'($signed(a_dy_ff))) <<< sh;

      b_side         = '0;
      b_side.mx      = a_mx_ff;
      b_side.my      = a_my_ff;
      b_side.adx     = adx_w[31:0];
      b_side.ady     = ady_w[31:0];
      b_side.dx_neg  = a_dx_ff[32];
      b_side.dx_zero = (a_dx_ff == '0);
      b_side.dy_neg  = a_dy_ff[32];
      b_side.dy_zero = (a_dy_ff == '0);
      b_side.zchord  = (a_dx_ff == '0) && (a_dy_ff == '0);
      b_side.zangle  = (a_ia_ff == '0);
      b_side.sh      = sh;
   end

   acrc_cordic_cell #(.STEP(0)) u_cell_in_unused_guard (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (a_valid_ff),
      .in_data   (b_in),
      .in_side   (b_side),
      .out_valid (cv[0]),
      .out_data  (cd[0]),
      .out_side  (cs[0])
   );

   // ---------------- cordic cells, one per step after the first ----------------
   for (genvar g = 1; g < CORDIC_STEPS; g++) begin : g_cordic
      acrc_cordic_cell #(.STEP(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (cv[g-1]),
         .in_data   (cd[g-1]),
         .in_side   (cs[g-1]),
         .out_valid (cv[g]),
         .out_data  (cd[g]),
         .out_side  (cs[g])
      );
   end

   // one register stage closing the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         cv[CORDIC_STEPS] <= 1'b0;
      end else if (adv) begin
         cv[CORDIC_STEPS] <= cv[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cd[CORDIC_STEPS] <= cd[CORDIC_STEPS-1];
         cs[CORDIC_STEPS] <= cs[CORDIC_STEPS-1];
      end
   end

   // ---------------- multiply stage ----------------
   always_comb begin
      c_v   = $signed(cd[CORDIC_STEPS].rx);
      s_v   = $signed(cd[CORDIC_STEPS].ry);
      l_v   = $signed(cd[CORDIC_STEPS].vx);
      c_abs = c_v[RW-1] ? -c_v : c_v;
      s_abs = s_v[RW-1] ? -s_v : s_v;
      m_px_in = 64'(cs[CORDIC_STEPS].ady) * 64'(c_abs[31:0]) + 64'(s_abs[31:0]);
      m_py_in = 64'(cs[CORDIC_STEPS].adx) * 64'(c_abs[31:0]) + 64'(s_abs[31:0]);
      m_lf_in = 64'(l_v[33:0]) * 64'(K_Q30[29:0]);
      m_side_in        = cs[CORDIC_STEPS];
      m_side_in.mag_s  = s_abs[31:0];
      m_side_in.szero  = (s_v == '0);
      m_side_in.cs_neg = c_v[RW-1] != s_v[RW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= cv[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_px_ff   <= m_px_in;
         m_py_ff   <= m_py_in;
         m_lf_ff   <= m_lf_in;
         m_side_ff <= m_side_in;
      end
   end

   // ---------------- scale stage: rounding and normalisation folded into the dividend ----
   assign numr_w = (65'(m_lf_ff) + (65'(m_side_ff.mag_s) << m_side_ff.sh))
                 >> (m_side_ff.sh + 5'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (adv) begin
         n_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_px_ff   <= m_px_ff;
         n_py_ff   <= m_py_ff;
         n_nr_ff   <= numr_w[63:0];
         n_side_ff <= m_side_ff;
      end
   end

   // ---------------- divider set-up: quotients too wide to hold are flagged here ----
   always_comb begin
      p_in.rem_x = n_px_ff;
      p_in.rem_y = n_py_ff;
      p_in.rem_r = n_nr_ff;
      p_in.den_o = {n_side_ff.mag_s[30:0], 1'b0};
      p_in.den_r = n_side_ff.mag_s;
      p_in.q_x   = '0;
      p_in.q_y   = '0;
      p_in.q_r   = '0;
      p_side       = n_side_ff;
      p_side.ovf_x = (n_px_ff >> QW) >= NW'(p_in.den_o);
      p_side.ovf_y = (n_py_ff >> QW) >= NW'(p_in.den_o);
      p_side.ovf_r = (n_nr_ff >> QW) >= NW'(p_in.den_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv[0] <= 1'b0;
      end else if (adv) begin
         dv[0] <= n_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dd[0] <= p_in;
         ds[0] <= p_side;
      end
   end

   // ---------------- divider cells, most significant quotient bit first ----------------
   for (genvar j = 0; j < QW; j++) begin : g_div
      acrc_div_cell #(.BIT_POS(QW - 1 - j)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (dv[j]),
         .in_data   (dd[j]),
         .in_side   (ds[j]),
         .out_valid (dv[j+1]),
         .out_data  (dd[j+1]),
         .out_side  (ds[j+1])
      );
   end

   // ---------------- output stage: signs, saturation and special cases ----------------
   always_comb begin
      fs = ds[QW];
      fd = dd[QW];
      // offset sign follows the normal component times cot
      neg_x  = (!fs.dy_neg) != fs.cs_neg;
      neg_y  = fs.dx_neg != fs.cs_neg;
      ox_sum = neg_x ? 35'($signed(fs.mx)) - $signed({2'b00, fd.q_x})
                     : 35'($signed(fs.mx)) + $signed({2'b00, fd.q_x});
      oy_sum = neg_y ? 35'($signed(fs.my)) - $signed({2'b00, fd.q_y})
                     : 35'($signed(fs.my)) + $signed({2'b00, fd.q_y});
      sat_x  = !fs.dy_zero
             && (fs.ovf_x || ox_sum > 35'($signed(I32_MAX)) || ox_sum < 35'($signed(I32_MIN)));
      sat_y  = !fs.dx_zero
             && (fs.ovf_y || oy_sum > 35'($signed(I32_MAX)) || oy_sum < 35'($signed(I32_MIN)));
      if (fs.dy_zero)  res_x = $signed(fs.mx);
      else if (sat_x)  res_x = neg_x ? I32_MIN : I32_MAX;
      else             res_x = ox_sum[31:0];
      if (fs.dx_zero)  res_y = $signed(fs.my);
      else if (sat_y)  res_y = neg_y ? I32_MIN : I32_MAX;
      else             res_y = oy_sum[31:0];
      sat_r = fs.ovf_r || (fd.q_r[QW-1:31] != '0);

      // centre pushed to infinity along the chord normal (-dy, dx)
      if (fs.dy_neg)       inf_x = I32_MAX;
      else if (!fs.dy_zero) inf_x = I32_MIN;
      else                 inf_x = $signed(fs.mx);
      if (fs.dx_neg)       inf_y = I32_MIN;
      else if (!fs.dx_zero) inf_y = I32_MAX;
      else                 inf_y = $signed(fs.my);

      if (fs.zchord) begin
         o_cx_in = fs.mx;
         o_cy_in = fs.my;
         o_r_in  = '0;
         o_st_in = ST_ZERO_CHORD;
      end else if (fs.zangle) begin
         o_cx_in = inf_x;
         o_cy_in = inf_y;
         o_r_in  = RAD_MAX;
         o_st_in = ST_ZERO_ANGLE;
      end else if (fs.szero) begin
         o_cx_in = inf_x;
         o_cy_in = inf_y;
         o_r_in  = RAD_MAX;
         o_st_in = ST_OVERFLOW;
      end else begin
         o_cx_in = res_x;
         o_cy_in = res_y;
         o_r_in  = sat_r ? RAD_MAX : fd.q_r[30:0];
         o_st_in = (sat_x || sat_y || sat_r) ? ST_OVERFLOW : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= dv[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_cx_ff <= o_cx_in;
         o_cy_ff <= o_cy_in;
         o_r_ff  <= o_r_in;
         o_st_ff <= o_st_in;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {1'b0, o_r_ff, o_cy_ff, o_cx_ff};
   assign rsp_tuser  = o_st_ff;

   // ---------------- assertions ----------------
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> a_valid_ff)
      else $error("accepted beat did not enter the input stage");

   a_chord_radius : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_ZERO_CHORD) |-> (rsp_tdata[94:64] == '0))
      else $error("zero chord with nonzero radius");

   a_angle_radius : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_ZERO_ANGLE) |-> (rsp_tdata[94:64] == RAD_MAX))
      else $error("zero angle without saturated radius");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv[QW]) && $stable(m_valid_ff))
      else $error("pipeline moved during a stall");

endmodule

// ===== rtl/acrc_cordic_cell.sv =====
// one cordic cell: a rotation step for the half angle and a vectoring step for the chord
`timescale 1ns / 1ps
module acrc_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  acrc_pkg::cordic_type in_data,
   input  acrc_pkg::side_type   in_side,
   output logic                 out_valid,
   output acrc_pkg::cordic_type out_data,
   output acrc_pkg::side_type   out_side
);
   import acrc_pkg::*;

   logic                 valid_ff;
   cordic_type           data_ff, data_in;
   side_type             side_ff;
   logic signed [RW-1:0] rx, ry, rz, rsx, rsy, at;
   logic signed [VW-1:0] vx, vy, vsx, vsy;

   always_comb begin
      rx  = $signed(in_data.rx);
      ry  = $signed(in_data.ry);
      rz  = $signed(in_data.rz);
      vx  = $signed(in_data.vx);
      vy  = $signed(in_data.vy);
      rsx = ry >>> STEP;
      rsy = rx >>> STEP;
      vsx = vy >>> STEP;
      vsy = vx >>> STEP;
      at  = atan_q30(STEP);
      if (!rz[RW-1]) begin
         data_in.rx = rx - rsx;
         data_in.ry = ry + rsy;
         data_in.rz = rz - at;
      end else begin
         data_in.rx = rx + rsx;
         data_in.ry = ry - rsy;
         data_in.rz = rz + at;
      end
      if (!vy[VW-1]) begin
         data_in.vx = vx + vsx;
         data_in.vy = vy - vsy;
      end else begin
         data_in.vx = vx - vsx;
         data_in.vy = vy + vsy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/acrc_div_cell.sv =====
// one divider cell: one quotient bit of each of the three quotients
`timescale 1ns / 1ps
module acrc_div_cell #(
   parameter int BIT_POS = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  acrc_pkg::div_type  in_data,
   input  acrc_pkg::side_type in_side,
   output logic               out_valid,
   output acrc_pkg::div_type  out_data,
   output acrc_pkg::side_type out_side
);
   import acrc_pkg::*;

   logic          valid_ff;
   div_type       data_ff, data_in;
   side_type      side_ff;
   logic [NW:0]   sx, sy, sr;

   always_comb begin
      sx = div_step(in_data.rem_x, in_data.den_o, BIT_POS);
      sy = div_step(in_data.rem_y, in_data.den_o, BIT_POS);
      sr = div_step(in_data.rem_r, in_data.den_r, BIT_POS);
      data_in = in_data;
      data_in.rem_x = sx[NW-1:0];
      data_in.rem_y = sy[NW-1:0];
      data_in.rem_r = sr[NW-1:0];
      data_in.q_x[BIT_POS] = sx[NW];
      data_in.q_y[BIT_POS] = sy[NW];
      data_in.q_r[BIT_POS] = sr[NW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_side  = side_ff;

endmodule
